[rtl/biq_pkg.sv]
// Shared types and constants for the biquad IIR filter.
// Used by the channel interfaces, the register block, the digit multiplier and the top level.
package biq_pkg;

	localparam int DEF_SAMPLE_BITS    = 16;
	localparam int DEF_COEF_FRAC_BITS = 20;

	// Coefficients are stored 24 bits wide, the delay words 32 bits wide.
	localparam int COEF_W     = 24;
	localparam int STATE_W    = 32;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = STATE_W / DIGIT_W;
	localparam int PROD_W     = COEF_W + STATE_W;

	localparam int NUM_COEFS = 5;
	localparam int REG_IDX_W = $clog2(NUM_COEFS);
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_B0 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_B1 = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_B2 = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_A1 = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_A2 = REG_IDX_W'(4);

	// Product terms in the order the sequencer works through them.
	localparam int TERM_W = 3;
	localparam logic [TERM_W-1:0] TERM_A1 = 3'd0;
	localparam logic [TERM_W-1:0] TERM_A2 = 3'd1;
	localparam logic [TERM_W-1:0] TERM_B0 = 3'd2;
	localparam logic [TERM_W-1:0] TERM_B1 = 3'd3;
	localparam logic [TERM_W-1:0] TERM_B2 = 3'd4;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coefs_t;

endpackage

[rtl/biq_stream_if.sv]
// Valid/ready channel interfaces for input samples and filtered results.
// Depends on biq_pkg for the default sample width.
interface biq_in_if import biq_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if import biq_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[rtl/biq_apb_regs.sv]
// APB coefficient register block of the biquad filter.
// Depends on biq_pkg for the register map and the coefficient struct.
module biq_apb_regs import biq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coefs_t            coefs
);

	coefs_t                 coefs_q;
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr_en;
	logic [COEF_W-1:0]      rd_coef;
	logic                   rd_hit;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coefs  = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (wr_en) begin
			// Indexes past the last coefficient are silently dropped.
			unique case (idx)
				REG_B0:  coefs_q.b0 <= pwdata[COEF_W-1:0];
				REG_B1:  coefs_q.b1 <= pwdata[COEF_W-1:0];
				REG_B2:  coefs_q.b2 <= pwdata[COEF_W-1:0];
				REG_A1:  coefs_q.a1 <= pwdata[COEF_W-1:0];
				REG_A2:  coefs_q.a2 <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rd_hit  = 1'b1;
		rd_coef = '0;
		unique case (idx)
			REG_B0:  rd_coef = coefs_q.b0;
			REG_B1:  rd_coef = coefs_q.b1;
			REG_B2:  rd_coef = coefs_q.b2;
			REG_A1:  rd_coef = coefs_q.a1;
			REG_A2:  rd_coef = coefs_q.a2;
			default: rd_hit  = 1'b0;
		endcase
	end

	assign prdata = rd_hit ? {{(DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef} : '0;

endmodule

[rtl/biq_digit_mul.sv]
// Digit-serial signed multiplier: coefficient times a delay word, one 8-bit digit a cycle.
// Depends on biq_pkg for the operand, digit and product widths.
module biq_digit_mul import biq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COEF_W-1:0]  coef,
	input  logic signed [STATE_W-1:0] operand,
	output logic signed [PROD_W-1:0]  product,
	output logic                      done
);

	localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [STATE_W-1:0]              shreg_q;
	logic signed [COEF_W-1:0]        coef_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic [DIGIT_W-1:0]              digit;
	logic signed [DIGIT_W:0]         sdigit;
	logic signed [COEF_W+DIGIT_W:0]  pp;

	// Digits leave the shift register most significant first; only the
	// first one carries the operand's sign.
	assign digit  = shreg_q[STATE_W-1 -: DIGIT_W];
	assign sdigit = {(cnt_q == '0) & digit[DIGIT_W-1], digit};
	assign pp     = coef_q * sdigit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_DIGIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= operand;
			coef_q  <= coef;
			prod_q  <= '0;
		end else if (busy_q) begin
			shreg_q <= shreg_q << DIGIT_W;
			prod_q  <= (prod_q <<< DIGIT_W) + PROD_W'(pp);
		end
	end

	assign product = prod_q;
	assign done    = done_q;

endmodule

[rtl/biquad_iir_filter.sv]
// Top level of the biquad IIR filter: sequencer, accumulator, rounding and saturation.
// Depends on biq_pkg, the channel interfaces, biq_apb_regs and biq_digit_mul.
//
// Second-order IIR section in direct form II. One input word gives one result word:
// the five products of the section run one after another through a single 24 x 8
// bit multiplier that takes each 32-bit delay word in four digits, and each sum is
// rounded and saturated. A new sample is taken once the previous one has left the
// sequencer; the result register lets it wait for the sink meanwhile. The
// coefficients are signed Q4.20 words at byte addresses 0, 4, 8, 12 and 16 (b0, b1,
// b2, a1, a2). The user must write them only while the filter is idle; the block
// itself does not enforce this. The clipped flag is set when the internal state or
// the output saturated for that sample.
module biquad_iir_filter import biq_pkg::*; #(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	biq_in_if.sink            sample,
	biq_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int ACC_W = ((PROD_W > SAMPLE_BITS + COEF_FRAC_BITS) ?
		PROD_W : SAMPLE_BITS + COEF_FRAC_BITS) + 3;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_RND   = 3'd4;
	localparam logic [2:0] ST_SAT   = 3'd5;

	coefs_t                        coefs;
	logic [2:0]                    state_q;
	logic [TERM_W-1:0]             term_q;
	logic signed [ACC_W-1:0]       sum_q;
	logic signed [STATE_W-1:0]     w0_q;
	logic signed [STATE_W-1:0]     w1_q;
	logic signed [STATE_W-1:0]     w2_q;
	logic                          hit_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_clip_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          mul_start;
	logic                          mul_done;
	logic signed [COEF_W-1:0]      mul_coef;
	logic signed [STATE_W-1:0]     mul_operand;
	logic signed [PROD_W-1:0]      mul_product;
	logic signed [ACC_W-1:0]       prod_ext;
	logic signed [ACC_W-1:0]       shifted;
	logic                          w0_fits;
	logic signed [STATE_W-1:0]     w0_sat;
	logic                          y_fits;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          feedback;

	biq_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	biq_digit_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.coef    (mul_coef),
		.operand (mul_operand),
		.product (mul_product),
		.done    (mul_done)
	);

	assign sample.ready = (state_q == ST_IDLE);
	assign in_fire      = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign mul_start    = (state_q == ST_START);
	assign feedback     = (term_q == TERM_A1) || (term_q == TERM_A2);

	always_comb begin
		mul_coef    = coefs.b0;
		mul_operand = w1_q;
		unique case (term_q)
			TERM_A1: begin
				mul_coef    = coefs.a1;
				mul_operand = w1_q;
			end
			TERM_A2: begin
				mul_coef    = coefs.a2;
				mul_operand = w2_q;
			end
			TERM_B0: begin
				mul_coef    = coefs.b0;
				mul_operand = w0_q;
			end
			TERM_B1: begin
				mul_coef    = coefs.b1;
				mul_operand = w1_q;
			end
			TERM_B2: begin
				mul_coef    = coefs.b2;
				mul_operand = w2_q;
			end
			default: ;
		endcase
	end

	assign prod_ext = {{(ACC_W-PROD_W){mul_product[PROD_W-1]}}, mul_product};

	// The rounding constant is already in the sum, so the arithmetic shift is the
	// floor that gives round half up.
	assign shifted = sum_q >>> COEF_FRAC_BITS;
	assign w0_fits = (&shifted[ACC_W-1:STATE_W-1]) || !(|shifted[ACC_W-1:STATE_W-1]);
	assign w0_sat  = w0_fits ? shifted[STATE_W-1:0] :
		{shifted[ACC_W-1], {(STATE_W-1){!shifted[ACC_W-1]}}};
	assign y_fits  = (&shifted[ACC_W-1:SAMPLE_BITS-1]) ||
		!(|shifted[ACC_W-1:SAMPLE_BITS-1]);
	assign y_sat   = y_fits ? shifted[SAMPLE_BITS-1:0] :
		{shifted[ACC_W-1], {(SAMPLE_BITS-1){!shifted[ACC_W-1]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= TERM_A1;
			w1_q        <= '0;
			w2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// When the next word is stored in the same cycle, the flag stays set.
			if (result.valid && result.ready &&
				!(state_q == ST_SAT && term_q != TERM_A2)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						term_q  <= TERM_A1;
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (term_q == TERM_A2 || term_q == TERM_B2) begin
						state_q <= ST_RND;
					end else begin
						term_q  <= term_q + TERM_W'(1);
						state_q <= ST_START;
					end
				end
				ST_RND: state_q <= ST_SAT;
				ST_SAT: begin
					if (term_q == TERM_A2) begin
						term_q  <= TERM_B0;
						state_q <= ST_START;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						w2_q        <= w1_q;
						w1_q        <= w0_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					sum_q <= {{(ACC_W-SAMPLE_BITS){sample.sample_in[SAMPLE_BITS-1]}},
						sample.sample_in} <<< COEF_FRAC_BITS;
					hit_q <= 1'b0;
				end
			end
			ST_ACC: sum_q <= feedback ? sum_q - prod_ext : sum_q + prod_ext;
			ST_RND: sum_q <= sum_q + HALF;
			ST_SAT: begin
				if (term_q == TERM_A2) begin
					w0_q  <= w0_sat;
					hit_q <= hit_q | !w0_fits;
					sum_q <= '0;
				end else if (out_free) begin
					out_data_q <= y_sat;
					out_clip_q <= hit_q | !y_fits;
				end
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;
	assign result.clipped    = out_clip_q;

endmodule

[rtl/biq_checker.sv]
// Port-level assertions for the biquad IIR filter, bound to the top level.
// Depends on biq_pkg for the default sample width.
module biq_checker import biq_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_data,
	input logic                   pready
);

	// A word keeps the block busy after it is taken, so the input is not taken again right away.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again right after a word");

	// No result can appear right after an input word is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after an input word");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result dropped or changed");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port stalled");

endmodule

bind biquad_iir_filter biq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.sample_out),
	.pready    (pready)
);
